FILE: src/ecl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression character lexer package
// Shared types and constants for the character-serial expression tokenizer:
// token classes, response kinds, error codes and the response record.
// ----------------------------------------------------------------------------
package ecl_pkg;

   // Longest token length that is counted before the count saturates.
   localparam int MAX_TOKEN_LEN = 255;
   localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);

   // Token classes; NONE means no token has been seen, BAD an undefined byte.
   typedef enum logic [2:0] {
      CLS_NUM   = 3'd0,
      CLS_WORD  = 3'd1,
      CLS_OPER  = 3'd2,
      CLS_OPEN  = 3'd3,
      CLS_CLOSE = 3'd4,
      CLS_COMMA = 3'd5,
      CLS_NONE  = 3'd6,
      CLS_BAD   = 3'd7
   } class_type;

   // Response kinds.
   typedef enum logic [1:0] {
      KIND_CHAR  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   // Error codes.
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_NON_ASCII = 2'd1,
      ERR_UNDEFINED = 2'd2,
      ERR_MULTI_DOT = 2'd3
   } err_type;

   // One response as it leaves the block.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] char_out;
      class_type  token_class;
      logic       first_of_token;
      logic [7:0] token_length;
      err_type    error_code;
      logic       last_of_run;
   } result_type;

   // All responses caused by one request, in delivery order.
   typedef struct packed {
      logic [1:0]             count;
      result_type [2:0]       item;
   } bundle_type;

endpackage

FILE: src/ecl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression lexer channels
// Valid/ready channel interfaces for the request (character) and response
// streams of the expression lexer.
// ----------------------------------------------------------------------------

// Request channel: one expression character per request.
interface ecl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       expr_last;

   modport source (output valid, output ch, output expr_last, input ready);
   modport sink   (input valid, input ch, input expr_last, output ready);
endinterface

// Response channel: tagged characters, completed tokens and errors.
interface ecl_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] char_out;
   logic [2:0] token_class;
   logic       first_of_token;
   logic [7:0] token_length;
   logic [1:0] error_code;
   logic       last_of_run;

   modport source (output valid, output kind, output char_out, output token_class,
                   output first_of_token, output token_length, output error_code,
                   output last_of_run, input ready);
   modport sink   (input valid, input kind, input char_out, input token_class,
                   input first_of_token, input token_length, input error_code,
                   input last_of_run, output ready);
endinterface

FILE: src/ecl_lexer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression lexer core
// Holds the token state and turns one request character into the bundle of
// up to three responses it causes, in a single pass of logic.
// ----------------------------------------------------------------------------
module ecl_lexer_core
   import ecl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] ch,
   input  logic       expr_last,
   output bundle_type bundle
);

   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_LPAR  = 8'h28;
   localparam logic [7:0] CH_RPAR  = 8'h29;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // Token state.
   class_type        prev_class_ff, prev_class_in;
   logic [LEN_W-1:0] open_len_ff, open_len_in;
   logic [1:0]       dot_cnt_ff, dot_cnt_in;
   logic             err_hold_ff, err_hold_in;

   logic             has_open;
   logic             pre_bad;
   logic             pre_close;
   logic             joins;
   logic             is_space;
   class_type        cls;
   logic [LEN_W-1:0] len_base, len_new;
   logic [1:0]       dot_base, dot_new;
   logic [1:0]       n;

   // Map a character to its token class.
   function automatic class_type classify(input logic [7:0] c);
      class_type r;
      if (c inside {[8'h30:8'h39], CH_DOT}) begin
         r = CLS_NUM;
      end else if (c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDER}) begin
         r = CLS_WORD;
      end else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT, CH_CARET}) begin
         r = CLS_OPER;
      end else if (c == CH_LPAR) begin
         r = CLS_OPEN;
      end else if (c == CH_RPAR) begin
         r = CLS_CLOSE;
      end else if (c == CH_COMMA) begin
         r = CLS_COMMA;
      end else begin
         r = CLS_BAD;
      end
      return r;
   endfunction

   // Token length as shown on the response, saturated to eight bits.
   function automatic logic [7:0] show_len(input logic [LEN_W-1:0] len);
      logic [LEN_W+7:0] wide;
      wide = {8'd0, len};
      return (wide > (LEN_W+8)'(255)) ? 8'hFF : wide[7:0];
   endfunction

   function automatic result_type blank();
      result_type r;
      r.kind           = KIND_CHAR;
      r.char_out       = 8'd0;
      r.token_class    = CLS_NUM;
      r.first_of_token = 1'b0;
      r.token_length   = 8'd0;
      r.error_code     = ERR_NONE;
      r.last_of_run    = 1'b0;
      return r;
   endfunction

   // Response that closes a token: a completion, or the multiple-dot error.
   function automatic result_type close_res(input class_type c, input logic [LEN_W-1:0] len,
                                            input logic [1:0] dots);
      result_type r;
      r = blank();
      r.token_length = show_len(len);
      if (c == CLS_NUM && dots > 2'd1) begin
         r.kind        = KIND_ERROR;
         r.token_class = CLS_NUM;
         r.error_code  = ERR_MULTI_DOT;
      end else begin
         r.kind        = KIND_DONE;
         r.token_class = c;
      end
      return r;
   endfunction

   function automatic result_type error_res(input logic [7:0] c, input err_type code);
      result_type r;
      r = blank();
      r.kind       = KIND_ERROR;
      r.char_out   = c;
      r.error_code = code;
      return r;
   endfunction

   function automatic result_type char_res(input logic [7:0] c, input class_type k,
                                           input logic first);
      result_type r;
      r = blank();
      r.char_out       = c;
      r.token_class    = k;
      r.first_of_token = first;
      return r;
   endfunction

   // Classification and the extended token state for a character.
   always_comb begin
      has_open  = (open_len_ff != '0);
      pre_bad   = has_open && (prev_class_ff == CLS_NUM) && (dot_cnt_ff > 2'd1);
      is_space  = (ch inside {CH_SPACE, [8'h09:8'h0D]});
      cls       = classify(ch);
      joins     = ((cls == CLS_NUM) || (cls == CLS_WORD)) && (cls == prev_class_ff) && has_open;
      pre_close = !joins && has_open;
      len_base  = joins ? open_len_ff : '0;
      len_new   = (len_base < LEN_W'(MAX_TOKEN_LEN)) ? len_base + 1'b1 : len_base;
      dot_base  = joins ? dot_cnt_ff : 2'd0;
      dot_new   = dot_base + {1'b0, (ch == CH_DOT) && (dot_base < 2'd2)};
   end

   // Responses and next state for the current request.
   always_comb begin
      prev_class_in = prev_class_ff;
      open_len_in   = open_len_ff;
      dot_cnt_in    = dot_cnt_ff;
      err_hold_in   = err_hold_ff;
      bundle.item[0] = blank();
      bundle.item[1] = blank();
      bundle.item[2] = blank();
      n = 2'd0;

      if (!err_hold_ff) begin
         if (ch[7]) begin
            bundle.item[0] = error_res(ch, ERR_NON_ASCII);
            n = 2'd1;
            err_hold_in = 1'b1;
         end else if (is_space) begin
            // White space closes the open token, if any.
            if (has_open) begin
               bundle.item[0] = close_res(prev_class_ff, open_len_ff, dot_cnt_ff);
               n = 2'd1;
            end
            if (pre_bad) begin
               err_hold_in = 1'b1;
            end
            open_len_in = '0;
            dot_cnt_in  = 2'd0;
         end else if (cls == CLS_BAD) begin
            bundle.item[0] = error_res(ch, ERR_UNDEFINED);
            n = 2'd1;
            err_hold_in = 1'b1;
         end else if (pre_close && pre_bad) begin
            // The closed number is rejected and this character is dropped.
            bundle.item[0] = close_res(prev_class_ff, open_len_ff, dot_cnt_ff);
            n = 2'd1;
            err_hold_in = 1'b1;
            open_len_in = '0;
            dot_cnt_in  = 2'd0;
         end else begin
            prev_class_in = cls;
            open_len_in   = len_new;
            dot_cnt_in    = dot_new;
            if (pre_close) begin
               bundle.item[0] = close_res(prev_class_ff, open_len_ff, dot_cnt_ff);
               bundle.item[1] = char_res(ch, cls, 1'b1);
               bundle.item[2] = close_res(cls, len_new, dot_new);
               n = expr_last ? 2'd3 : 2'd2;
            end else begin
               bundle.item[0] = char_res(ch, cls, !joins);
               bundle.item[1] = close_res(cls, len_new, dot_new);
               n = expr_last ? 2'd2 : 2'd1;
            end
         end
      end

      // Mark the final response of this request.
      case (n)
         2'd1:    bundle.item[0].last_of_run = 1'b1;
         2'd2:    bundle.item[1].last_of_run = 1'b1;
         2'd3:    bundle.item[2].last_of_run = 1'b1;
         default: ;
      endcase
      bundle.count = n;

      // The end of an expression returns everything to the idle state.
      if (expr_last) begin
         prev_class_in = CLS_NONE;
         open_len_in   = '0;
         dot_cnt_in    = 2'd0;
         err_hold_in   = 1'b0;
      end
   end

   // State update on each accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_class_ff <= CLS_NONE;
         open_len_ff   <= '0;
         dot_cnt_ff    <= 2'd0;
         err_hold_ff   <= 1'b0;
      end else if (accept) begin
         prev_class_ff <= prev_class_in;
         open_len_ff   <= open_len_in;
         dot_cnt_ff    <= dot_cnt_in;
         err_hold_ff   <= err_hold_in;
      end
   end

   // A dropped request after an error must not produce responses.
   assert property (@(posedge clock) disable iff (reset)
      (accept && err_hold_ff) |-> (bundle.count == 2'd0))
      else $error("responses produced while dropping after an error");

   // Dots are only counted inside an open number.
   assert property (@(posedge clock) disable iff (reset)
      (dot_cnt_ff != 2'd0) |-> (prev_class_ff == CLS_NUM && open_len_ff != '0))
      else $error("dot count outside an open number");

   // A third response only comes with the closing at the end of an expression.
   assert property (@(posedge clock) disable iff (reset)
      (accept && bundle.count == 2'd3) |-> expr_last)
      else $error("three responses without the end of an expression");

endmodule

FILE: src/ecl_rsp_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression lexer response buffer
// Registers the responses of one request and hands them out one per cycle
// on the response channel while the receiver is ready, head first.
// ----------------------------------------------------------------------------
module ecl_rsp_buf
   import ecl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_fire,
   input  bundle_type bundle,
   output logic       can_load,
   input  logic       rsp_ready,
   output logic       rsp_valid,
   output result_type rsp_head
);

   result_type [2:0] entries_ff, entries_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             pop;
   logic             load;

   // Handshake: a new bundle fits once the last held response leaves.
   always_comb begin
      pop       = (cnt_ff != 2'd0) && rsp_ready;
      can_load  = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop);
      load      = req_fire && (bundle.count != 2'd0);
      rsp_valid = (cnt_ff != 2'd0);
      rsp_head  = entries_ff[0];
   end

   // Next contents: load a new bundle or shift toward the head.
   always_comb begin
      entries_in = entries_ff;
      cnt_in     = cnt_ff;
      if (load) begin
         entries_in = bundle.item;
         cnt_in     = bundle.count;
      end else if (pop) begin
         entries_in[0] = entries_ff[1];
         entries_in[1] = entries_ff[2];
         cnt_in        = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      entries_ff <= entries_in;
   end

   // A bundle is never loaded over responses still waiting.
   assert property (@(posedge clock) disable iff (reset)
      load |-> ((cnt_ff == 2'd0) || (cnt_ff == 2'd1 && pop)))
      else $error("response bundle overwritten");

   // The run marker appears only on the last held response.
   assert property (@(posedge clock) disable iff (reset)
      (cnt_ff != 2'd0 && entries_ff[0].last_of_run) |-> (cnt_ff == 2'd1))
      else $error("run marker before the end of the bundle");

   // Each delivered response without a new load reduces the count by one.
   assert property (@(posedge clock) disable iff (reset)
      (pop && !load) |=> (cnt_ff == $past(cnt_ff) - 2'd1))
      else $error("response count did not follow delivery");

endmodule

FILE: src/expression_char_lexer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression character lexer
// Splits a character stream into number, word, operator, parenthesis and
// comma tokens, tagging each character and reporting completed tokens.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one expression byte per request (ch) and expr_last on
//   the final byte of an expression. rsp_bus returns tagged characters,
//   token completions and errors; last_of_run marks the final response of
//   a request. A request causes zero to three responses.
//   The first response of a request is valid in the cycle after the
//   request is accepted. One request is taken per cycle while each causes
//   at most one response and the receiver is ready; a request with more
//   holds the response register until its last response leaves, and the
//   next request is taken in that cycle, also one that causes no responses itself.
//   After an error the rest of the expression is consumed without responses.
//   When the receiver stalls, the held responses stay stable and req ready
//   drops once the next request could not be stored.
//   Synchronous reset clears the token state and empties the response
//   register; no request is lost by it beyond those already in flight.
// ----------------------------------------------------------------------------
module expression_char_lexer_unit
   import ecl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   ecl_req_if.sink          req_bus,
   ecl_rsp_if.source        rsp_bus
);

   bundle_type bundle;
   result_type head;
   logic       can_load;
   logic       req_fire;

   // Request handshake.
   assign req_bus.ready = can_load;
   assign req_fire      = req_bus.valid && can_load;

   ecl_lexer_core u_core (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_fire),
      .ch        (req_bus.ch),
      .expr_last (req_bus.expr_last),
      .bundle    (bundle)
   );

   ecl_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .bundle    (bundle),
      .can_load  (can_load),
      .rsp_ready (rsp_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_head  (head)
   );

   // Response payload.
   assign rsp_bus.kind           = head.kind;
   assign rsp_bus.char_out       = head.char_out;
   assign rsp_bus.token_class    = head.token_class;
   assign rsp_bus.first_of_token = head.first_of_token;
   assign rsp_bus.token_length   = head.token_length;
   assign rsp_bus.error_code     = head.error_code;
   assign rsp_bus.last_of_run    = head.last_of_run;

endmodule
